// ----- sv/hsv_pkg.sv -----
package hsv_pkg;

  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_W         = 15;
  localparam int CH_W          = 8;

  localparam int SECTOR_UNITS = 60 << HUE_FRAC_BITS;
  localparam int CIRCLE_UNITS = 360 << HUE_FRAC_BITS;
  localparam int CIRC_W       = $clog2(CIRCLE_UNITS + 1);
  localparam int WK           = ((HUE_W > CIRC_W) ? HUE_W : CIRC_W) + 1;
  localparam int D_W          = $clog2(SECTOR_UNITS + 1);

  // hue modulo circle: reciprocal estimate, low by at most one
  localparam int KC   = HUE_W + 1;
  localparam int MC   = (1 << KC) / CIRCLE_UNITS;
  localparam int MC_W = $clog2(MC + 2);
  localparam int PC_W = HUE_W + MC_W;
  localparam int RW   = HUE_W + CIRC_W;

  // channel level: v * (255*D - s*k) / (255*D)
  localparam int LEV_W     = $clog2(255 * SECTOR_UNITS + 1);
  localparam int N_W       = LEV_W + CH_W;
  localparam int LVL_SHIFT = HUE_FRAC_BITS + 2;
  localparam int LVL_DIV   = (255 * SECTOR_UNITS) / (1 << LVL_SHIFT);
  localparam int X_W       = $clog2(255 * LVL_DIV + 1);
  localparam int KQ        = 32;
  localparam longint MQ    = (64'd1 << KQ) / LVL_DIV;
  localparam int MQ_W      = $clog2(MQ + 1);
  localparam int PQ_W      = X_W + MQ_W;

  typedef logic [HUE_W-1:0] hue_t;
  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [D_W-1:0]   krem_t;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic ld_in;
    logic ld_mulc;
    logic ld_mod;
    logic ld_sect;
    logic ld_diff;
    logic ld_num;
    logic ld_recip;
    logic ld_out;
  } pipe_ld_t;

endpackage

// ----- sv/hsv_in_if.sv -----
interface hsv_in_if import hsv_pkg::*; ();
  logic  valid;
  logic  ready;
  hue_t  hue;
  chan_t saturation;
  chan_t brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

// ----- sv/hsv_out_if.sv -----
interface hsv_out_if import hsv_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ----- sv/hsv_to_rgb_converter.sv -----
// channel  dir  handshake            payload
// pix_in   in   valid / ready        hue[14:0], saturation[7:0], brightness[7:0]
// pix_out  out  valid / ready        red[7:0], green[7:0], blue[7:0]
//
// eight register stages, one item per cycle while pix_out is ready
// depth set by hue modulo, sector split and the reciprocal divide per channel
// rst clears all stage valid bits, payload registers are not reset
// each stage loads when empty or when the next stage loads, so bubbles close
// a held output stalls the pipe back to pix_in only once all stages are full
module hsv_to_rgb_converter import hsv_pkg::*; (
  input logic       clk,
  input logic       rst,
  hsv_in_if.sink    pix_in,
  hsv_out_if.source pix_out
);

  pipe_ld_t   ld;
  logic [7:0] vld;

  hue_t    h1;
  chan_t   s1, s2, s3, s4;
  chan_t   v1, v2, v3, v4, v5, v6, v7;
  sector_t sector4, sec5, sec6, sec7;
  krem_t   rem4, rem_inv4;
  chan_t   lvl_p, lvl_q, lvl_t;
  chan_t   red, green, blue;
  chan_t   red_next, green_next, blue_next;

  always_comb begin
    ld.ld_out   = !vld[7] || pix_out.ready;
    ld.ld_recip = !vld[6] || ld.ld_out;
    ld.ld_num   = !vld[5] || ld.ld_recip;
    ld.ld_diff  = !vld[4] || ld.ld_num;
    ld.ld_sect  = !vld[3] || ld.ld_diff;
    ld.ld_mod   = !vld[2] || ld.ld_sect;
    ld.ld_mulc  = !vld[1] || ld.ld_mod;
    ld.ld_in    = !vld[0] || ld.ld_mulc;
  end

  assign pix_in.ready  = ld.ld_in;
  assign pix_out.valid = vld[7];
  assign pix_out.red   = red;
  assign pix_out.green = green;
  assign pix_out.blue  = blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld.ld_in)    vld[0] <= pix_in.valid;
      if (ld.ld_mulc)  vld[1] <= vld[0];
      if (ld.ld_mod)   vld[2] <= vld[1];
      if (ld.ld_sect)  vld[3] <= vld[2];
      if (ld.ld_diff)  vld[4] <= vld[3];
      if (ld.ld_num)   vld[5] <= vld[4];
      if (ld.ld_recip) vld[6] <= vld[5];
      if (ld.ld_out)   vld[7] <= vld[6];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_in) begin
      h1 <= pix_in.hue;
      s1 <= pix_in.saturation;
      v1 <= pix_in.brightness;
    end
    if (ld.ld_mulc) begin
      s2 <= s1;
      v2 <= v1;
    end
    if (ld.ld_mod) begin
      s3 <= s2;
      v3 <= v2;
    end
    if (ld.ld_sect) begin
      s4 <= s3;
      v4 <= v3;
    end
    if (ld.ld_diff) begin
      v5   <= v4;
      sec5 <= sector4;
    end
    if (ld.ld_num) begin
      v6   <= v5;
      sec6 <= sec5;
    end
    if (ld.ld_recip) begin
      v7   <= v6;
      sec7 <= sec6;
    end
  end

  hsv_hue_split u_split (
    .clk     (clk),
    .ld      (ld),
    .hue     (h1),
    .sector  (sector4),
    .rem     (rem4),
    .rem_inv (rem_inv4)
  );

  hsv_level_unit u_level_p (
    .clk   (clk),
    .ld    (ld),
    .s     (s4),
    .v     (v4),
    .k     (D_W'(SECTOR_UNITS)),
    .level (lvl_p)
  );

  hsv_level_unit u_level_q (
    .clk   (clk),
    .ld    (ld),
    .s     (s4),
    .v     (v4),
    .k     (rem4),
    .level (lvl_q)
  );

  hsv_level_unit u_level_t (
    .clk   (clk),
    .ld    (ld),
    .s     (s4),
    .v     (v4),
    .k     (rem_inv4),
    .level (lvl_t)
  );

  always_comb begin
    case (sec7)
      SEC_RY: begin
        red_next = v7;    green_next = lvl_t; blue_next = lvl_p;
      end
      SEC_YG: begin
        red_next = lvl_q; green_next = v7;    blue_next = lvl_p;
      end
      SEC_GC: begin
        red_next = lvl_p; green_next = v7;    blue_next = lvl_t;
      end
      SEC_CB: begin
        red_next = lvl_p; green_next = lvl_q; blue_next = v7;
      end
      SEC_BM: begin
        red_next = lvl_t; green_next = lvl_p; blue_next = v7;
      end
      default: begin
        red_next = v7;    green_next = lvl_p; blue_next = lvl_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld.ld_out) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  a_room_when_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> pix_in.ready)
    else $error("input stage empty but not ready");

  a_drain_to_out: assert property (@(posedge clk) disable iff (rst)
    vld[6] && !vld[7] |=> vld[7])
    else $error("item lost before output register");

  a_levels_below_v: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (lvl_p <= v7) && (lvl_q <= v7) && (lvl_t <= v7))
    else $error("channel level above value");

  a_p_lowest: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (lvl_p <= lvl_q) && (lvl_p <= lvl_t))
    else $error("p level above q or t");

endmodule

// ----- sv/hsv_hue_split.sv -----
module hsv_hue_split import hsv_pkg::*; (
  input  logic     clk,
  input  pipe_ld_t ld,
  input  hue_t     hue,
  output sector_t  sector,
  output krem_t    rem,
  output krem_t    rem_inv
);

  localparam logic [MC_W-1:0] MC_C = MC_W'(MC);

  hue_t              h2;
  logic [PC_W-1:0]   pc2;
  hue_t              hm;
  hue_t              qc;
  logic [RW-1:0]     prod_c;
  logic [RW-1:0]     hr;
  hue_t              hm_next;
  logic [WK-1:0]     hm_w;
  logic [WK-1:0]     base;
  sector_t           sector_next;

  always_ff @(posedge clk) begin
    if (ld.ld_mulc) begin
      h2  <= hue;
      pc2 <= PC_W'(hue) * PC_W'(MC_C);
    end
  end

  // one correction step after the reciprocal estimate
  always_comb begin
    qc     = HUE_W'(pc2 >> KC);
    prod_c = RW'(qc) * RW'(CIRCLE_UNITS);
    hr     = RW'(h2) - prod_c;
    if (hr >= RW'(CIRCLE_UNITS)) begin
      hm_next = HUE_W'(hr - RW'(CIRCLE_UNITS));
    end else begin
      hm_next = HUE_W'(hr);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_mod) begin
      hm <= hm_next;
    end
  end

  always_comb begin
    hm_w        = WK'(hm);
    base        = '0;
    sector_next = SEC_RY;
    for (int j = 1; j < 6; j++) begin
      if (hm_w >= WK'(j * SECTOR_UNITS)) begin
        base        = WK'(j * SECTOR_UNITS);
        sector_next = sector_t'(3'(j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_sect) begin
      sector  <= sector_next;
      rem     <= D_W'(hm_w - base);
      rem_inv <= D_W'(WK'(SECTOR_UNITS) + base - hm_w);
    end
  end

endmodule

// ----- sv/hsv_level_unit.sv -----
module hsv_level_unit import hsv_pkg::*; (
  input  logic     clk,
  input  pipe_ld_t ld,
  input  chan_t    s,
  input  chan_t    v,
  input  krem_t    k,
  output chan_t    level
);

  localparam logic [LEV_W-1:0] LEV_TOP = LEV_W'(255 * SECTOR_UNITS);
  localparam logic [MQ_W-1:0]  MQ_C    = MQ_W'(MQ);

  logic [LEV_W-1:0] a5;
  chan_t            v5;
  logic [N_W-1:0]   n;
  logic [X_W-1:0]   x6;
  logic [X_W-1:0]   x7;
  logic [PQ_W-1:0]  pq7;
  chan_t            qe;
  logic [X_W-1:0]   back;
  logic [X_W-1:0]   r;

  always_ff @(posedge clk) begin
    if (ld.ld_diff) begin
      a5 <= LEV_TOP - LEV_W'(s) * LEV_W'(k);
      v5 <= v;
    end
  end

  assign n = N_W'(v5) * N_W'(a5);

  always_ff @(posedge clk) begin
    if (ld.ld_num) begin
      x6 <= X_W'(n >> LVL_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_recip) begin
      pq7 <= PQ_W'(x6) * PQ_W'(MQ_C);
      x7  <= x6;
    end
  end

  // estimate is exact or one low
  always_comb begin
    qe   = CH_W'(pq7 >> KQ);
    back = X_W'(qe) * X_W'(LVL_DIV);
    r    = x7 - back;
    if (r >= X_W'(LVL_DIV)) begin
      level = qe + CH_W'(1);
    end else begin
      level = qe;
    end
  end

endmodule
